@@ hdl/sorted_list_insert_table_assert.svh @@
// Assertion macros for the sorted insertion table.
`ifndef SORTED_LIST_INSERT_TABLE_ASSERT_SVH
`define SORTED_LIST_INSERT_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sli_pkg.sv @@
// Shared types and constants for the sorted insertion table.
package sli_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int VAL_W           = 32;

	typedef logic signed [VAL_W-1:0] value_t;

	typedef enum logic [1:0] {
		KIND_INSERTED = 2'd0,
		KIND_FULL     = 2'd1,
		KIND_LISTED   = 2'd2,
		KIND_EMPTY    = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REQ_INSERT  = 1'b0,
		REQ_READOUT = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SHIFT,
		ST_PLACE,
		ST_LIST,
		ST_EMIT
	} state_t;

	// Sequencer to datapath
	typedef struct packed {
		logic  req_ready;
		logic  load_item;
		logic  mem_we;
		logic  wr_item;
		logic  res_load;
		logic  res_from_mem;
		kind_t res_kind;
		logic  res_last;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic req_valid;
		req_t req_type;
		logic res_free;
		logic key_gt;
	} sts_t;

endpackage

@@ hdl/sli_if.sv @@
// Request and result channel interfaces for the sorted insertion table.
interface sli_req_if;
	import sli_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface sli_res_if;
	import sli_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              result_kind;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last_result;

	modport source (output valid, output result_kind, output entry_value,
		output last_result, input ready);
	modport sink   (input valid, input result_kind, input entry_value,
		input last_result, output ready);
endinterface

@@ hdl/sli_mem.sv @@
// Entry store: one write port, one read port with registered read data.
module sli_mem #(
	parameter int  DEPTH = sli_pkg::TABLE_DEPTH_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   wr_addr,
	input  sli_pkg::value_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output sli_pkg::value_t rd_data
);
	import sli_pkg::*;

	value_t mem_q [DEPTH];
	value_t rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/sli_ctrl.sv @@
// Sequencer: entry count, walk index and the insert / read-out steps.
module sli_ctrl #(
	parameter int  DEPTH = sli_pkg::TABLE_DEPTH_DEF,
	localparam int AW    = $clog2(DEPTH),
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sli_pkg::sts_t  sts,
	output sli_pkg::ctrl_t ctrl,
	output logic [AW-1:0]  wr_addr,
	output logic [AW-1:0]  rd_addr,
	output logic [CW-1:0]  count
);
	import sli_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;
	kind_t         kind_q, kind_d;
	req_t          req_q, req_d;
	logic          full;
	logic          last;

	assign full  = (count_q == CW'(DEPTH));
	assign last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			kind_q  <= KIND_INSERTED;
			req_q   <= REQ_INSERT;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			kind_q  <= kind_d;
			req_q   <= req_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.req_valid) state_d = ST_START;
			end
			ST_START: begin
				if (req_q == REQ_INSERT) begin
					if (full)                state_d = ST_EMIT;
					else if (count_q == '0) state_d = ST_PLACE;
					else                     state_d = ST_SHIFT;
				end else begin
					if (count_q == '0) state_d = ST_EMIT;
					else               state_d = ST_LIST;
				end
			end
			ST_SHIFT: begin
				if (!sts.key_gt)              state_d = ST_EMIT;
				else if (idx_q == AW'(1))     state_d = ST_PLACE;
			end
			ST_PLACE: state_d = ST_EMIT;
			ST_LIST: begin
				if (sts.res_free && last) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and counter updates
	always_comb begin
		ctrl          = '0;
		ctrl.res_kind = kind_q;
		idx_d         = idx_q;
		count_d       = count_q;
		kind_d        = kind_q;
		req_d         = req_q;
		wr_addr       = idx_q;
		rd_addr       = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.req_ready = 1'b1;
				if (sts.req_valid) begin
					ctrl.load_item = 1'b1;
					req_d          = sts.req_type;
				end
			end
			ST_START: begin
				if (req_q == REQ_INSERT) begin
					if (full) begin
						kind_d = KIND_FULL;
					end else begin
						kind_d  = KIND_INSERTED;
						idx_d   = count_q[AW-1:0];
						rd_addr = count_q[AW-1:0] - AW'(1);
					end
				end else begin
					kind_d  = (count_q == '0) ? KIND_EMPTY : KIND_LISTED;
					idx_d   = '0;
					rd_addr = '0;
				end
			end
			ST_SHIFT: begin
				// read data holds the entry just below idx
				ctrl.mem_we = 1'b1;
				if (sts.key_gt) begin
					idx_d   = idx_q - AW'(1);
					rd_addr = idx_q - AW'(2);
				end else begin
					ctrl.wr_item = 1'b1;
					count_d      = count_q + CW'(1);
				end
			end
			ST_PLACE: begin
				ctrl.mem_we  = 1'b1;
				ctrl.wr_item = 1'b1;
				count_d      = count_q + CW'(1);
			end
			ST_LIST: begin
				if (sts.res_free) begin
					ctrl.res_load     = 1'b1;
					ctrl.res_from_mem = 1'b1;
					ctrl.res_kind     = KIND_LISTED;
					ctrl.res_last     = last;
					if (!last) begin
						idx_d   = idx_q + AW'(1);
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			ST_EMIT: begin
				if (sts.res_free) begin
					ctrl.res_load = 1'b1;
					ctrl.res_last = 1'b1;
				end
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

@@ hdl/sorted_list_insert_table.sv @@
// Top level of the sorted insertion table: item register, compare, result register.
//
//   channel | dir | payload                                  | transfer
//   req     | in  | req_type, item_value                      | valid && ready
//   res     | out | result_kind, entry_value, last_result     | valid && ready
//
// Insert: each stored entry greater than the new value moves up one place
// (one compare-and-move step per cycle through the single store write port).
// Read out: one listed entry per cycle while res is ready.
// Full and empty answers are single status results. req is ready only in idle.
// Reset empties the table by clearing the entry count; no clearing pass.
// A stalled res holds the sequencer in place; nothing is dropped.
`include "sorted_list_insert_table_assert.svh"

module sorted_list_insert_table #(
	parameter int TABLE_DEPTH = sli_pkg::TABLE_DEPTH_DEF
) (
	input logic   clk,
	input logic   arst_n,
	sli_req_if.sink   req,
	sli_res_if.source res
);
	import sli_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	ctrl_t         ctrl;
	sts_t          sts;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count;
	value_t        rd_data;
	value_t        wr_data;
	value_t        item_q;

	logic          res_valid_q;
	kind_t         res_kind_q;
	value_t        res_value_q;
	logic          res_last_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			item_q <= req.item_value;
		end
	end

	assign sts.req_valid = req.valid;
	assign sts.req_type  = req_t'(req.req_type);
	assign sts.res_free  = !res_valid_q || res.ready;
	assign sts.key_gt    = (rd_data > item_q);

	assign wr_data = ctrl.wr_item ? item_q : rd_data;

	sli_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.sts     (sts),
		.ctrl    (ctrl),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.count   (count)
	);

	sli_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
		.clk     (clk),
		.we      (ctrl.mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			res_kind_q  <= ctrl.res_kind;
			res_value_q <= ctrl.res_from_mem ? rd_data : '0;
			res_last_q  <= ctrl.res_last;
		end
	end

	assign req.ready       = ctrl.req_ready;
	assign res.valid       = res_valid_q;
	assign res.result_kind = res_kind_q;
	assign res.entry_value = res_value_q;
	assign res.last_result = res_last_q;

	`SLI_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "req ready right after a transfer")
	`SLI_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "entry count beyond table depth")
	`SLI_ASSERT_NOW(a_status_final, res.valid && res.result_kind != KIND_LISTED, res.last_result && res.entry_value == '0, "status result not final or nonzero")
	`SLI_ASSERT_NOW(a_write_busy, ctrl.mem_we, !req.ready, "store written while idle")

endmodule

@@ bench/tb.sv @@
// Testbench for sorted_list_insert_table: directed and random request traffic checked against a table model.
`timescale 1ns / 1ps

module tb;
	import sli_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int RAND_ITEMS = 110;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 60;
	localparam int TAIL_WAIT  = 40;

	typedef struct packed {
		req_t        op;
		value_t      value;
		logic [1:0]  gap;
		logic        drain;
	} table_req_t;

	typedef struct packed {
		kind_t  kind;
		value_t value;
		logic   fin;
	} table_answer_t;

	logic clk = 1'b0;
	logic arst_n;

	sli_req_if req_ch ();
	sli_res_if res_ch ();

	sorted_list_insert_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the table contents
	value_t        table_vals [DEPTH];
	int            table_count = 0;
	table_answer_t owed_answers [$];
	table_req_t    pending_reqs [$];
	int            results_owed = 0;
	int            results_got  = 0;
	int            errors       = 0;
	int            req_idx      = 0;
	int            fill_gen     = 0;

	// Apply one request to the model, queue its answers, return how many.
	function automatic int predict_answers(req_t op, value_t v);
		int            pos;
		int            i;
		table_answer_t a;
		if (op == REQ_INSERT) begin
			a.value = '0;
			a.fin   = 1'b1;
			if (table_count >= DEPTH) begin
				a.kind = KIND_FULL;
			end else begin
				// equal values keep arrival order: new one goes after them
				pos = 0;
				while (pos < table_count && table_vals[pos] <= v)
					pos++;
				for (i = table_count; i > pos; i--)
					table_vals[i] = table_vals[i-1];
				table_vals[pos] = v;
				table_count++;
				a.kind = KIND_INSERTED;
			end
			owed_answers.push_back(a);
			return 1;
		end
		if (table_count == 0) begin
			a.kind  = KIND_EMPTY;
			a.value = '0;
			a.fin   = 1'b1;
			owed_answers.push_back(a);
			return 1;
		end
		for (i = 0; i < table_count; i++) begin
			a.kind  = KIND_LISTED;
			a.value = table_vals[i];
			a.fin   = (i == table_count - 1);
			owed_answers.push_back(a);
		end
		return table_count;
	endfunction

	function automatic value_t pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 8) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(req_t op, value_t v, logic drain);
		table_req_t r;
		r.op    = op;
		r.value = v;
		r.drain = drain;
		// every so often a run of back-to-back items
		r.gap   = (req_idx % 40 < 10) ? 2'd0 : 2'($urandom_range(0, 3));
		pending_reqs.push_back(r);
		req_idx++;
		if (op == REQ_INSERT && fill_gen < DEPTH)
			fill_gen++;
	endtask

	// request driver
	logic [1:0] tx_gap;
	table_req_t cur_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.req_type   <= REQ_INSERT;
			req_ch.item_value <= '0;
			tx_gap = '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				results_owed <= results_owed +
					predict_answers(req_t'(req_ch.req_type), req_ch.item_value);
			if (!req_ch.valid || req_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap = tx_gap - 1'b1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() == 0 || (pending_reqs[0].drain &&
						(req_ch.valid || results_owed != results_got))) begin
					req_ch.valid <= 1'b0;
				end else begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.req_type   <= cur_req.op;
					req_ch.item_value <= cur_req.value;
					if (pending_reqs.size() > 0)
						tx_gap = pending_reqs[0].gap;
				end
			end
		end
	end

	// result monitor and checker
	int            rx_wait;
	int            hold_left;
	int            seen;
	table_answer_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_wait   = 0;
			hold_left = 0;
			seen      = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_got <= results_got + 1;
				seen++;
				if (owed_answers.size() == 0) begin
					$display("%0t: unexpected result: got kind %0d value %0d last %0b",
						$time, res_ch.result_kind, res_ch.entry_value, res_ch.last_result);
					errors++;
				end else begin
					want = owed_answers.pop_front();
					if (res_ch.result_kind !== want.kind || res_ch.entry_value !== want.value ||
							res_ch.last_result !== want.fin) begin
						$display("%0t: mismatch: expected kind %0d value %0d last %0b, got kind %0d value %0d last %0b",
							$time, want.kind, want.value, want.fin,
							res_ch.result_kind, res_ch.entry_value, res_ch.last_result);
						errors++;
					end
				end
				rx_wait = (seen % 64 < 12) ? 0 : $urandom_range(0, 3);
				// long back-pressure so the block stalls its input
				if (seen == 30 || seen == 150)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: no transfer on either side for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_INSERT;
		req_ch.item_value = '0;
		res_ch.ready      = 1'b0;

		// directed: empty read-out, extremes, duplicates at both ends and middle
		add_req(REQ_READOUT, 32'sh5a5a5a5a, 1'b0);
		add_req(REQ_INSERT, 32'sd0, 1'b0);
		add_req(REQ_INSERT, 32'sh7fffffff, 1'b0);
		add_req(REQ_INSERT, 32'sh80000000, 1'b0);
		add_req(REQ_INSERT, -32'sd1, 1'b0);
		add_req(REQ_READOUT, -32'sd1, 1'b0);
		add_req(REQ_INSERT, 32'sd1, 1'b0);
		add_req(REQ_INSERT, 32'sd0, 1'b0);
		add_req(REQ_INSERT, 32'sh7fffffff, 1'b0);
		add_req(REQ_INSERT, 32'sh80000000, 1'b0);
		add_req(REQ_READOUT, 32'sd0, 1'b1);

		for (int n = 0; n < RAND_ITEMS; n++)
			add_req(($urandom_range(0, 9) < 3) ? REQ_INSERT : REQ_READOUT, pick_value(),
				(n == 50 || $urandom_range(0, 19) == 0));

		// make sure the table ends up full, then overflow it
		while (fill_gen < DEPTH)
			add_req(REQ_INSERT, pick_value(), 1'b0);
		add_req(REQ_INSERT, 32'sh7fffffff, 1'b0);
		add_req(REQ_INSERT, 32'sh80000000, 1'b0);
		add_req(REQ_READOUT, 32'sh0, 1'b0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_reqs.size() > 0 || req_ch.valid || results_owed != results_got)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (owed_answers.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, owed_answers.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
